FILE: hw/rtl/first_fit_heap_allocator_top_macros.svh
// Assertion macros of the heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

   localparam int LINK_W    = 15;
   localparam int HDR_W     = 16;
   localparam int HDR_BYTES = 2;

   localparam logic [HDR_W-1:0] USED_FLAG = 16'h8000;
   localparam logic [HDR_W-1:0] LINK_MASK = 16'h7FFF;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_REINIT = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_ZERO_SIZE = 2'd1,
      ST_NO_FIT    = 2'd2
   } status_type;

   // One write port and one read port into the header store, by byte offset.
   typedef struct packed {
      logic              wr_en;
      logic [LINK_W-1:0] wr_off;
      logic [HDR_W-1:0]  wr_data;
      logic [LINK_W-1:0] rd_off;
   } ram_cmd_type;

endpackage

FILE: hw/rtl/ffha_header_ram.sv
// Header store: one 16-bit header per even byte offset, registered read.
module ffha_header_ram #(
   parameter int HEAP_BYTES = 1024
) (
   input  logic                     clock,
   input  ffha_pkg::ram_cmd_type    cmd,
   output logic [ffha_pkg::HDR_W-1:0] rd_data
);
   import ffha_pkg::*;

   localparam int DEPTH = HEAP_BYTES / 2;
   localparam int IDX_W = $clog2(DEPTH);

   logic [HDR_W-1:0] mem [DEPTH];
   logic [HDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_off[IDX_W:1]] <= cmd.wr_data;
      end
      rd_data_ff <= mem[cmd.rd_off[IDX_W:1]];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator with merge-on-free.
//
// Each request is taken alone and answered with exactly one result. Allocate
// and free walk the block chain one header at a time through a single read
// port of the header store: S_ISSUE addresses each header visited and S_EVAL
// evaluates it with the shared subtract-and-compare unit; S_SPLIT writes
// the remainder header when a block is split. Free first reads the block's
// header in S_FREE_RD and, for a valid address, clears its used flag in
// S_FREE_WR, then walks the whole chain. A used block spans at least four
// bytes and a free one at least two, and no two free blocks stay adjacent,
// so the chain holds at most about HEAP_BYTES/3 headers. Reinitialise, a
// zero-size request, a free of address zero and opcode 3 go straight to the
// result without walking the chain. After reset the block writes the
// initial header in S_INIT before it accepts a request. The result sits in
// an output register, so the next request is taken while the previous
// result waits for rsp_tready.
`include "first_fit_heap_allocator_top_macros.svh"

module first_fit_heap_allocator_top #(
   parameter int HEAP_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // request_bytes [10:0], block_address [20:11], zero [23:21]
   input  logic [1:0]  req_tuser,  // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // payload_address [9:0], zero [15:10]
   output logic [1:0]  rsp_tuser   // status [1:0]
);
   import ffha_pkg::*;

   localparam logic [HDR_W-1:0] HEAP_END = HDR_W'(HEAP_BYTES) & ~HDR_W'(1);
   localparam int OFF_W = $clog2(HEAP_BYTES + 1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_FREE_RD, S_FREE_WR, S_ISSUE, S_EVAL, S_SPLIT, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   opcode_type       op_ff, op_in;
   logic [11:0]      size_ff, size_in;
   logic [9:0]       baddr_ff, baddr_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [OFF_W-1:0] last_ff, last_in;
   logic             have_last_ff, have_last_in;
   logic [OFF_W-1:0] split_ff, split_in;
   logic [OFF_W-1:0] next_ff, next_in;
   status_type       status_ff, status_in;
   logic [9:0]       paddr_ff, paddr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [9:0]       rsp_paddr_ff, rsp_paddr_in;

   ram_cmd_type      ram_cmd;
   logic [HDR_W-1:0] hdr;

   logic [HDR_W-1:0] hdr_next, off16, avail, size16, split16, baddr16, hoff16;
   logic             hdr_used, link_ok, fits, exact, free_ok, slot_free;
   logic [10:0]      req_bytes;
   logic [9:0]       req_baddr;

   ffha_header_ram #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_ram (
      .clock  (clock),
      .cmd    (ram_cmd),
      .rd_data(hdr)
   );

   assign req_bytes = req_tdata[10:0];
   assign req_baddr = req_tdata[20:11];

   // Shared subtract-and-compare unit working on the header just read.
   always_comb begin
      hdr_next = {1'b0, hdr[LINK_W-1:0]};
      hdr_used = hdr[HDR_W-1];
      off16    = HDR_W'(off_ff);
      size16   = HDR_W'(size_ff);
      link_ok  = (hdr_next > off16) && (hdr_next <= HEAP_END) && !hdr_next[0];
      avail    = hdr_next - off16 - HDR_W'(HDR_BYTES);
      fits     = !hdr_used && (avail >= size16);
      exact    = (avail == size16);
      split16  = off16 + HDR_W'(HDR_BYTES) + size16;
      baddr16  = HDR_W'(baddr_ff);
      hoff16   = baddr16 - HDR_W'(HDR_BYTES);
      free_ok  = !baddr_ff[0] && (baddr16 >= HDR_W'(HDR_BYTES)) && (hoff16 < HEAP_END);
   end

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      baddr_in     = baddr_ff;
      off_in       = off_ff;
      last_in      = last_ff;
      have_last_in = have_last_ff;
      split_in     = split_ff;
      next_in      = next_ff;
      status_in    = status_ff;
      paddr_in     = paddr_ff;

      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_off  = LINK_W'(off_ff);
      ram_cmd.wr_data = '0;
      ram_cmd.rd_off  = LINK_W'(off_ff);

      case (state_ff)
         S_INIT: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_off  = '0;
            ram_cmd.wr_data = HEAP_END;
            state_in        = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in        = opcode_type'(req_tuser);
               size_in      = (12'(req_bytes) + 12'd1) & ~12'd1;
               baddr_in     = req_baddr;
               off_in       = '0;
               have_last_in = 1'b0;
               status_in    = ST_DONE;
               paddr_in     = '0;
               state_in     = S_DONE;
               case (opcode_type'(req_tuser))
                  OP_ALLOC: begin
                     if (req_bytes == 11'd0) begin
                        status_in = ST_ZERO_SIZE;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
                  OP_FREE: begin
                     if (req_baddr != 10'd0) begin
                        state_in = S_FREE_RD;
                     end
                  end
                  OP_REINIT: begin
                     ram_cmd.wr_en   = 1'b1;
                     ram_cmd.wr_off  = '0;
                     ram_cmd.wr_data = HEAP_END;
                  end
                  default: ;
               endcase
            end
         end
         S_FREE_RD: begin
            ram_cmd.rd_off = LINK_W'(hoff16);
            state_in       = free_ok ? S_FREE_WR : S_ISSUE;
         end
         S_FREE_WR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_off  = LINK_W'(hoff16);
            ram_cmd.wr_data = hdr & LINK_MASK;
            state_in        = S_ISSUE;
         end
         S_ISSUE: begin
            // read of the header at off is under way; stop at the heap end
            if (off16 >= HEAP_END) begin
               if (op_ff == OP_ALLOC) status_in = ST_NO_FIT;
               state_in = S_DONE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!link_ok) begin
               if (op_ff == OP_ALLOC) status_in = ST_NO_FIT;
               state_in = S_DONE;
            end else if (op_ff == OP_ALLOC) begin
               if (fits) begin
                  ram_cmd.wr_en = 1'b1;
                  paddr_in      = 10'(off16 + HDR_W'(HDR_BYTES));
                  if (exact) begin
                     ram_cmd.wr_data = hdr | USED_FLAG;
                     state_in        = S_DONE;
                  end else begin
                     ram_cmd.wr_data = split16 | USED_FLAG;
                     split_in        = OFF_W'(split16);
                     next_in         = OFF_W'(hdr_next);
                     state_in        = S_SPLIT;
                  end
               end else begin
                  off_in   = OFF_W'(hdr_next);
                  state_in = S_ISSUE;
               end
            end else begin
               // merge walk: fold each free block into the first of its run
               if (!hdr_used) begin
                  if (have_last_ff) begin
                     ram_cmd.wr_en   = 1'b1;
                     ram_cmd.wr_off  = LINK_W'(last_ff);
                     ram_cmd.wr_data = hdr_next;
                  end else begin
                     last_in      = off_ff;
                     have_last_in = 1'b1;
                  end
               end else begin
                  have_last_in = 1'b0;
               end
               off_in   = OFF_W'(hdr_next);
               state_in = S_ISSUE;
            end
         end
         S_SPLIT: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_off  = LINK_W'(split_ff);
            ram_cmd.wr_data = HDR_W'(next_ff);
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_paddr_in  = rsp_paddr_ff;
      if (state_ff == S_DONE && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_paddr_in  = paddr_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_last_ff <= have_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      size_ff       <= size_in;
      baddr_ff      <= baddr_in;
      off_ff        <= off_in;
      last_ff       <= last_in;
      split_ff      <= split_in;
      next_ff       <= next_in;
      status_ff     <= status_in;
      paddr_ff      <= paddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_paddr_ff  <= rsp_paddr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_paddr_ff};
   assign rsp_tuser  = rsp_status_ff;

   `FFHA_ASSERT_NEXT(a_accept_leaves_idle, req_tvalid && req_tready, state_ff != S_IDLE, "request transfer did not start work")
   `FFHA_ASSERT_NOW(a_write_in_heap, ram_cmd.wr_en, HDR_W'(ram_cmd.wr_off) < HEAP_END, "header write beyond heap end")
   `FFHA_ASSERT_NOW(a_walk_even, state_ff == S_EVAL, !off_ff[0], "chain walk at odd offset")
   `FFHA_ASSERT_NOW(a_addr_only_on_done, rsp_tvalid && (rsp_tdata[9:0] != 10'd0), rsp_tuser == ST_DONE, "payload address on failed result")
   `FFHA_ASSERT_NEXT(a_done_loads_rsp, state_ff == S_DONE && slot_free, rsp_tvalid, "finished result not presented")

endmodule
